// File: rtl/chain_coordinate_liftover_defines.svh
// Assertion macros used by the checker file of the chain coordinate liftover block.
`ifndef CHAIN_COORDINATE_LIFTOVER_DEFINES_SVH
`define CHAIN_COORDINATE_LIFTOVER_DEFINES_SVH

// Checked on every rising edge outside reset.
`define CCL_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");

// Checked on every rising edge, reset included.
`define CCL_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");

`endif

// File: rtl/ccl_pkg.sv
// Shared types and constants of the chain coordinate liftover block.
`timescale 1ns / 1ps
`default_nettype none

package ccl_pkg;

  localparam int FIELD_W   = 32;
  localparam int S_TDATA_W = 7 * FIELD_W;
  localparam int M_TDATA_W = 2 * FIELD_W;

  localparam int FOS_LSB = 0;
  localparam int FNS_LSB = FIELD_W;
  localparam int LEN_LSB = 2 * FIELD_W;
  localparam int GO_LSB  = 3 * FIELD_W;
  localparam int GN_LSB  = 4 * FIELD_W;
  localparam int QS_LSB  = 5 * FIELD_W;
  localparam int QE_LSB  = 6 * FIELD_W;

  typedef enum logic [1:0] {
    ACT_CHAIN = 2'd0,
    ACT_BLOCK = 2'd1,
    ACT_LAST  = 2'd2,
    ACT_QUERY = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CHAIN,
    OP_LAST_BLK,
    OP_LATCH,
    OP_BLK_WR,
    OP_Q_INIT,
    OP_TOP,
    OP_BELOW,
    OP_BS_INIT,
    OP_BS_UPD,
    OP_LO_INC,
    OP_MAP,
    OP_NX_CAP,
    OP_FAIL,
    OP_NEXT_END,
    OP_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    RD_FILL,
    RD_LAST,
    RD_ZERO,
    RD_MID,
    RD_LOP1,
    RD_LO,
    RD_NX
  } rd_sel_t;

  typedef enum logic [13:0] {
    ST_IDLE    = 14'b00000000000001,
    ST_LD_WR   = 14'b00000000000010,
    ST_Q_LAST  = 14'b00000000000100,
    ST_Q_FIRST = 14'b00000000001000,
    ST_Q_FCMP  = 14'b00000000010000,
    ST_BS_CHK  = 14'b00000000100000,
    ST_BS_CMP  = 14'b00000001000000,
    ST_SC_CHK  = 14'b00000010000000,
    ST_SC_CMP  = 14'b00000100000000,
    ST_MAP_RD  = 14'b00001000000000,
    ST_MAP_CMP = 14'b00010000000000,
    ST_NX_CAP  = 14'b00100000000000,
    ST_END     = 14'b01000000000000,
    ST_FIN     = 14'b10000000000000
  } state_t;

  typedef struct packed {
    dp_op_t  op;
    rd_sel_t rd;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic fill_full;
    logic x_gt_rd;
    logic x_lt_rd;
    logic x_eq_rd;
    logic bs_more;
    logic lo_lt_last;
    logic in_blk;
    logic nx_need;
    logic is_start;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/chain_coordinate_liftover.sv
// Top level of the chain coordinate liftover block: controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Holds one alignment chain as a table of up to MAX_BLOCKS aligned blocks and lifts
// query intervals from old to new coordinates through it. A chain start or a last block
// is handled in the idle state; an inner block adds a write state (read the previous
// starts, then write). A query locates each end by a binary search where needed, then
// scans over each extra block whose old start equals a searched coordinate; while the
// chain is empty, both ends fail without a search. The search pace is set by the single
// read port of the old-start table: each binary-search probe is a read state followed
// by a compare state. A finished result waits in an output register while the
// next item is taken; no result is produced for load items, and the tables need no
// clearing pass after reset.
module chain_coordinate_liftover #(
  parameter int MAX_BLOCKS = 4096,
  parameter int COORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // first_old_start, first_new_start, block_len, gap_old, gap_new, query_start, query_end
  input  logic [ccl_pkg::S_TDATA_W-1:0]   s_tdata,
  // action
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // lifted_start, lifted_end
  output logic [ccl_pkg::M_TDATA_W-1:0]   m_tdata,
  // lifted_ok
  output logic [0:0]                      m_tuser
);

  ccl_pkg::ctrl_cmd_t cmd;
  ccl_pkg::dp_stat_t  stat;

  ccl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ccl_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

// File: rtl/ccl_ctrl.sv
// Controller state machine that sequences table loads and the two searches of a query.
`timescale 1ns / 1ps
`default_nettype none

module ccl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic [1:0]          s_tuser,
  output logic                s_tready,
  input  ccl_pkg::dp_stat_t   stat,
  output ccl_pkg::ctrl_cmd_t  cmd
);

  ccl_pkg::state_t  state;
  ccl_pkg::state_t  state_next;
  ccl_pkg::action_t act;

  assign act      = ccl_pkg::action_t'(s_tuser);
  assign s_tready = (state == ccl_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = ccl_pkg::OP_NONE;
    cmd.rd     = ccl_pkg::RD_FILL;
    case (state)
      ccl_pkg::ST_IDLE: begin
        cmd.rd = ccl_pkg::RD_FILL;
        if (s_tvalid) begin
          case (act)
            ccl_pkg::ACT_CHAIN: begin
              cmd.op = ccl_pkg::OP_CHAIN;
            end
            ccl_pkg::ACT_BLOCK: begin
              if (!stat.fill_full) begin
                cmd.op     = ccl_pkg::OP_LATCH;
                state_next = ccl_pkg::ST_LD_WR;
              end
            end
            ccl_pkg::ACT_LAST: begin
              cmd.op = ccl_pkg::OP_LAST_BLK;
            end
            ccl_pkg::ACT_QUERY: begin
              cmd.op     = ccl_pkg::OP_Q_INIT;
              state_next = ccl_pkg::ST_Q_LAST;
            end
            default: begin
              cmd.op = ccl_pkg::OP_NONE;
            end
          endcase
        end
      end
      ccl_pkg::ST_LD_WR: begin
        cmd.op     = ccl_pkg::OP_BLK_WR;
        state_next = ccl_pkg::ST_IDLE;
      end
      ccl_pkg::ST_Q_LAST: begin
        if (stat.cnt_zero) begin
          cmd.op     = ccl_pkg::OP_FAIL;
          state_next = ccl_pkg::ST_END;
        end else begin
          cmd.rd     = ccl_pkg::RD_LAST;
          state_next = ccl_pkg::ST_Q_FIRST;
        end
      end
      ccl_pkg::ST_Q_FIRST: begin
        if (stat.x_gt_rd) begin
          cmd.op     = ccl_pkg::OP_TOP;
          state_next = ccl_pkg::ST_MAP_RD;
        end else begin
          cmd.rd     = ccl_pkg::RD_ZERO;
          state_next = ccl_pkg::ST_Q_FCMP;
        end
      end
      ccl_pkg::ST_Q_FCMP: begin
        if (stat.x_lt_rd) begin
          cmd.op     = ccl_pkg::OP_BELOW;
          state_next = ccl_pkg::ST_MAP_RD;
        end else begin
          cmd.op     = ccl_pkg::OP_BS_INIT;
          state_next = ccl_pkg::ST_BS_CHK;
        end
      end
      ccl_pkg::ST_BS_CHK: begin
        if (stat.bs_more) begin
          cmd.rd     = ccl_pkg::RD_MID;
          state_next = ccl_pkg::ST_BS_CMP;
        end else begin
          state_next = ccl_pkg::ST_SC_CHK;
        end
      end
      ccl_pkg::ST_BS_CMP: begin
        cmd.op     = ccl_pkg::OP_BS_UPD;
        state_next = ccl_pkg::ST_BS_CHK;
      end
      ccl_pkg::ST_SC_CHK: begin
        if (stat.lo_lt_last) begin
          cmd.rd     = ccl_pkg::RD_LOP1;
          state_next = ccl_pkg::ST_SC_CMP;
        end else begin
          state_next = ccl_pkg::ST_MAP_RD;
        end
      end
      ccl_pkg::ST_SC_CMP: begin
        if (stat.x_eq_rd) begin
          cmd.op     = ccl_pkg::OP_LO_INC;
          state_next = ccl_pkg::ST_SC_CHK;
        end else begin
          state_next = ccl_pkg::ST_MAP_RD;
        end
      end
      ccl_pkg::ST_MAP_RD: begin
        cmd.rd     = ccl_pkg::RD_LO;
        state_next = ccl_pkg::ST_MAP_CMP;
      end
      ccl_pkg::ST_MAP_CMP: begin
        cmd.op = ccl_pkg::OP_MAP;
        cmd.rd = ccl_pkg::RD_NX;
        if (stat.nx_need && !stat.in_blk) begin
          state_next = ccl_pkg::ST_NX_CAP;
        end else begin
          state_next = ccl_pkg::ST_END;
        end
      end
      ccl_pkg::ST_NX_CAP: begin
        cmd.op     = ccl_pkg::OP_NX_CAP;
        state_next = ccl_pkg::ST_END;
      end
      ccl_pkg::ST_END: begin
        if (stat.is_start) begin
          cmd.op     = ccl_pkg::OP_NEXT_END;
          state_next = ccl_pkg::ST_Q_LAST;
        end else begin
          state_next = ccl_pkg::ST_FIN;
        end
      end
      ccl_pkg::ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.op     = ccl_pkg::OP_OUT;
          state_next = ccl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ccl_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/ccl_dpath.sv
// Datapath with the block tables, search registers, end mapping and output register.
`timescale 1ns / 1ps
`default_nettype none

module ccl_dpath #(
  parameter int MAX_BLOCKS = 4096,
  parameter int COORD_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [ccl_pkg::S_TDATA_W-1:0]   s_tdata,
  input  ccl_pkg::ctrl_cmd_t              cmd,
  output ccl_pkg::dp_stat_t               stat,
  input  logic                            m_tready,
  output logic                            m_tvalid,
  output logic [ccl_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic [0:0]                      m_tuser
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = IDX_W + 1;
  localparam int W     = COORD_BITS;

  logic [W-1:0] old_mem [MAX_BLOCKS];
  logic [W-1:0] new_mem [MAX_BLOCKS];
  logic [W-1:0] len_mem [MAX_BLOCKS];
  logic [W-1:0] rd_old;
  logic [W-1:0] rd_new;
  logic [W-1:0] rd_len;

  logic [CNT_W-1:0] fill;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] lo;
  logic [IDX_W-1:0] hi;
  logic             below;
  logic             is_start;
  logic [W-1:0]     x;
  logic [W-1:0]     qend;
  logic [W-1:0]     lat_len;
  logic [W-1:0]     lat_go;
  logic [W-1:0]     lat_gn;
  logic [W-1:0]     res_s;
  logic [W-1:0]     res_e;
  logic             ok_s;
  logic             ok_e;
  logic             out_valid;
  logic             out_ok;
  logic [ccl_pkg::FIELD_W-1:0] out_start;
  logic [ccl_pkg::FIELD_W-1:0] out_end;

  logic [W-1:0] in_fos;
  logic [W-1:0] in_fns;
  logic [W-1:0] in_len;
  logic [W-1:0] in_go;
  logic [W-1:0] in_gn;
  logic [W-1:0] in_qs;
  logic [W-1:0] in_qe;

  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] lo_p1;
  logic [CNT_W-1:0] sum_lh;
  logic [IDX_W-1:0] mid_c;
  logic [IDX_W-1:0] fill_idx;
  logic [IDX_W-1:0] fill_p1_idx;
  logic             fill_full;
  logic             next_ok;
  logic             lo_lt_last;
  logic             in_blk;
  logic             nx_need;
  logic [W-1:0]     blk_end;
  logic [W-1:0]     map_res;
  logic [W-1:0]     snap_end;
  logic             out_ok_c;

  logic [IDX_W-1:0] rd_idx;
  logic             tab_we;
  logic [IDX_W-1:0] tab_idx;
  logic [W-1:0]     old_wdata;
  logic [W-1:0]     new_wdata;
  logic             len_we;
  logic [W-1:0]     len_wdata;

  logic             res_we;
  logic             res_ok;
  logic [W-1:0]     res_val;

  assign in_fos = W'(s_tdata[ccl_pkg::FOS_LSB +: ccl_pkg::FIELD_W]);
  assign in_fns = W'(s_tdata[ccl_pkg::FNS_LSB +: ccl_pkg::FIELD_W]);
  assign in_len = W'(s_tdata[ccl_pkg::LEN_LSB +: ccl_pkg::FIELD_W]);
  assign in_go  = W'(s_tdata[ccl_pkg::GO_LSB +: ccl_pkg::FIELD_W]);
  assign in_gn  = W'(s_tdata[ccl_pkg::GN_LSB +: ccl_pkg::FIELD_W]);
  assign in_qs  = W'(s_tdata[ccl_pkg::QS_LSB +: ccl_pkg::FIELD_W]);
  assign in_qe  = W'(s_tdata[ccl_pkg::QE_LSB +: ccl_pkg::FIELD_W]);

  assign last_idx    = IDX_W'(count - CNT_W'(1));
  assign lo_p1       = lo + IDX_W'(1);
  assign sum_lh      = {1'b0, lo} + {1'b0, hi};
  assign mid_c       = sum_lh[IDX_W:1];
  assign fill_idx    = fill[IDX_W-1:0];
  assign fill_p1_idx = IDX_W'(fill + CNT_W'(1));
  assign fill_full   = (fill >= CNT_W'(MAX_BLOCKS));
  assign next_ok     = ((fill + CNT_W'(1)) < CNT_W'(MAX_BLOCKS));
  assign lo_lt_last  = (({1'b0, lo} + CNT_W'(1)) < count);
  assign blk_end     = rd_old + rd_len;
  assign in_blk      = !below && (x < blk_end);
  assign nx_need     = is_start && (below || lo_lt_last);
  assign map_res     = rd_new + x - rd_old;
  assign snap_end    = rd_new + rd_len - W'(1);
  assign out_ok_c    = ok_s && ok_e && (res_e >= res_s);

  assign stat.cnt_zero   = (count == '0);
  assign stat.fill_full  = fill_full;
  assign stat.x_gt_rd    = (x > rd_old);
  assign stat.x_lt_rd    = (x < rd_old);
  assign stat.x_eq_rd    = (x == rd_old);
  assign stat.bs_more    = ({1'b0, hi} > ({1'b0, lo} + CNT_W'(1)));
  assign stat.lo_lt_last = lo_lt_last;
  assign stat.in_blk     = in_blk;
  assign stat.nx_need    = nx_need;
  assign stat.is_start   = is_start;
  assign stat.out_busy   = out_valid && !m_tready;

  always_comb begin
    case (cmd.rd)
      ccl_pkg::RD_FILL: rd_idx = fill_idx;
      ccl_pkg::RD_LAST: rd_idx = last_idx;
      ccl_pkg::RD_ZERO: rd_idx = '0;
      ccl_pkg::RD_MID:  rd_idx = mid_c;
      ccl_pkg::RD_LOP1: rd_idx = lo_p1;
      ccl_pkg::RD_LO:   rd_idx = lo;
      ccl_pkg::RD_NX:   rd_idx = below ? '0 : lo_p1;
      default:          rd_idx = '0;
    endcase
  end

  always_comb begin
    tab_we    = 1'b0;
    tab_idx   = '0;
    old_wdata = in_fos;
    new_wdata = in_fns;
    len_we    = 1'b0;
    len_wdata = in_len;
    case (cmd.op)
      ccl_pkg::OP_CHAIN: begin
        tab_we = 1'b1;
      end
      ccl_pkg::OP_BLK_WR: begin
        tab_we    = next_ok;
        tab_idx   = fill_p1_idx;
        old_wdata = rd_old + lat_len + lat_go;
        new_wdata = rd_new + lat_len + lat_gn;
        len_we    = !fill_full;
        len_wdata = lat_len;
      end
      ccl_pkg::OP_LAST_BLK: begin
        len_we = !fill_full;
      end
      default: begin
        tab_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      old_mem[tab_idx] <= old_wdata;
    end
    rd_old <= old_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      new_mem[tab_idx] <= new_wdata;
    end
    rd_new <= new_mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[fill_idx] <= len_wdata;
    end
    rd_len <= len_mem[rd_idx];
  end

  always_comb begin
    res_we  = 1'b0;
    res_ok  = 1'b0;
    res_val = '0;
    case (cmd.op)
      ccl_pkg::OP_MAP: begin
        if (in_blk) begin
          res_we  = 1'b1;
          res_ok  = 1'b1;
          res_val = map_res;
        end else if (!nx_need) begin
          res_we  = 1'b1;
          res_ok  = !is_start && !below;
          res_val = snap_end;
        end
      end
      ccl_pkg::OP_NX_CAP: begin
        res_we  = 1'b1;
        res_ok  = 1'b1;
        res_val = rd_new;
      end
      ccl_pkg::OP_FAIL: begin
        res_we = 1'b1;
      end
      default: begin
        res_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      count <= '0;
    end else begin
      case (cmd.op)
        ccl_pkg::OP_CHAIN: begin
          fill  <= '0;
          count <= '0;
        end
        ccl_pkg::OP_BLK_WR: begin
          if (!fill_full) begin
            fill <= fill + CNT_W'(1);
          end
        end
        ccl_pkg::OP_LAST_BLK: begin
          if (!fill_full) begin
            fill  <= fill + CNT_W'(1);
            count <= fill + CNT_W'(1);
          end else begin
            count <= fill;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      ccl_pkg::OP_LATCH: begin
        lat_len <= in_len;
        lat_go  <= in_go;
        lat_gn  <= in_gn;
      end
      ccl_pkg::OP_Q_INIT: begin
        x        <= in_qs;
        qend     <= in_qe;
        is_start <= 1'b1;
      end
      ccl_pkg::OP_NEXT_END: begin
        x        <= qend;
        is_start <= 1'b0;
      end
      ccl_pkg::OP_TOP: begin
        lo    <= last_idx;
        below <= 1'b0;
      end
      ccl_pkg::OP_BELOW: begin
        below <= 1'b1;
      end
      ccl_pkg::OP_BS_INIT: begin
        lo    <= '0;
        hi    <= last_idx;
        below <= 1'b0;
      end
      ccl_pkg::OP_BS_UPD: begin
        if (rd_old > x) begin
          hi <= mid_c;
        end else begin
          lo <= mid_c;
        end
      end
      ccl_pkg::OP_LO_INC: begin
        lo <= lo_p1;
      end
      default: begin
        lo <= lo;
      end
    endcase
    if (res_we) begin
      if (is_start) begin
        res_s <= res_val;
        ok_s  <= res_ok;
      end else begin
        res_e <= res_val;
        ok_e  <= res_ok;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == ccl_pkg::OP_OUT) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ccl_pkg::OP_OUT) begin
      out_ok    <= out_ok_c;
      out_start <= out_ok_c ? ccl_pkg::FIELD_W'(res_s) : '0;
      out_end   <= out_ok_c ? ccl_pkg::FIELD_W'(res_e) : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_end, out_start};
  assign m_tuser  = out_ok;

endmodule

`default_nettype wire

// File: rtl/ccl_checker.sv
// Port-level assertion checker for the chain coordinate liftover block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

`include "chain_coordinate_liftover_defines.svh"

module ccl_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [1:0]                    s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [ccl_pkg::M_TDATA_W-1:0] m_tdata,
  input logic [0:0]                    m_tuser
);

  logic s_xfer;
  logic q_xfer;

  assign s_xfer = s_tvalid && s_tready;
  assign q_xfer = s_xfer && (s_tuser == ccl_pkg::ACT_QUERY);

  `CCL_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> (s_tready && !m_tvalid))
  `CCL_ASSERT(a_out_hold, clk, rst, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
  `CCL_ASSERT(a_fail_zero, clk, rst, (m_tvalid && !m_tuser[0]) |-> (m_tdata == '0))
  `CCL_ASSERT(a_load_silent, clk, rst, (s_xfer && !q_xfer) |=> !$rose(m_tvalid))
  `CCL_ASSERT(a_query_busy, clk, rst, q_xfer |=> !s_tready)

endmodule

bind chain_coordinate_liftover ccl_checker u_ccl_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
